>>> hw/rtl/rfpdp_pkg.sv
// rfpdp_pkg: shared constants, beat types and stage structs of the seven-frame
// path score datapath. No dependencies; every other file of the block imports it.
`default_nettype none

package rfpdp_pkg;

  // Fixed geometry of the frame set
  localparam int FRAME_COUNT    = 7;
  localparam int FRAME_BITS     = 3;
  localparam int CODING_ROWS    = FRAME_COUNT - 1;
  localparam int PHASE_BITS     = 2;

  // Field widths
  localparam int CELL_BITS      = 32;
  localparam int PEN_BITS       = 32;
  localparam int OUT_BITS       = 32;
  localparam int ADD_BITS       = CELL_BITS + 2;   // cell plus twice the penalty
  localparam int SCORE_BITS_DEF = 32;

  // Score memory: two slots per coding row
  localparam int MEM_DEPTH      = 2 * CODING_ROWS;
  localparam int MEM_ADDR_BITS  = $clog2(MEM_DEPTH);

  // Row codes
  localparam logic [FRAME_BITS-1:0] ROW_FIRST     = 3'd0;  // frame +1, opens a column
  localparam logic [FRAME_BITS-1:0] ROW_STRAND    = 3'd3;  // first reverse row, strand offset
  localparam logic [FRAME_BITS-1:0] ROW_NONCODING = 3'd6;
  localparam logic [FRAME_BITS-1:0] ROW_INVALID   = 3'd7;

  localparam logic [PHASE_BITS-1:0] PHASE_FIRST   = 2'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_LAST    = 2'd2;

  typedef struct packed {
    logic                        sequence_start;
    logic [FRAME_BITS-1:0]       frame_index;
    logic signed [CELL_BITS-1:0] cell_score;
  } rfpdp_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] path_score;
    logic [FRAME_BITS-1:0]      back_frame;
  } rfpdp_out_t;

  // Beat held between issue and select
  typedef struct packed {
    logic [FRAME_BITS-1:0]      row;
    logic                       first_col;
    logic                       three_pred;
    logic                       bad;
    logic                       byp_a;
    logic                       byp_b;
    logic [FRAME_BITS-1:0]      row_a;
    logic [FRAME_BITS-1:0]      row_b;
    logic signed [ADD_BITS-1:0] cell_ext;
    logic signed [ADD_BITS-1:0] add6;
    logic signed [ADD_BITS-1:0] addb;
    logic [MEM_ADDR_BITS-1:0]   waddr;
  } rfpdp_issue_t;

  // Write-back of a finished score
  typedef struct packed {
    logic                     we;
    logic                     row6;
    logic [MEM_ADDR_BITS-1:0] waddr;
  } rfpdp_wb_t;

endpackage

`default_nettype wire

>>> hw/rtl/rfpdp_score_mem.sv
// rfpdp_score_mem: column score memory, two slots per coding row, one write and
// two registered reads per cycle, per-entry valid bits. Uses rfpdp_pkg.
`default_nettype none

module rfpdp_score_mem #(
  parameter int SCORE_BITS = rfpdp_pkg::SCORE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [rfpdp_pkg::MEM_ADDR_BITS-1:0]  rd_addr_a_i,
  input  logic [rfpdp_pkg::MEM_ADDR_BITS-1:0]  rd_addr_b_i,
  input  logic                                 wr_en_i,
  input  logic [rfpdp_pkg::MEM_ADDR_BITS-1:0]  wr_addr_i,
  input  logic signed [SCORE_BITS-1:0]         wr_data_i,
  output logic signed [SCORE_BITS-1:0]         rd_data_a_o,
  output logic signed [SCORE_BITS-1:0]         rd_data_b_o
);
  import rfpdp_pkg::*;

  logic signed [SCORE_BITS-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]         vld_q;
  logic signed [SCORE_BITS-1:0] data_a_q, data_b_q;
  logic                         vld_a_q, vld_b_q;

  // Storage write, read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_a_q <= mem[rd_addr_a_i];
      data_b_q <= mem[rd_addr_b_i];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_a_q <= vld_q[rd_addr_a_i];
        vld_b_q <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = vld_a_q ? data_a_q : '0;
  assign rd_data_b_o = vld_b_q ? data_b_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/rfpdp_issue.sv
// rfpdp_issue: column tracking, slot pointers, predecessor address generation,
// penalty pre-add, bypass capture and the noncoding row registers. Uses rfpdp_pkg.
`default_nettype none

module rfpdp_issue #(
  parameter int SCORE_BITS = rfpdp_pkg::SCORE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  rfpdp_pkg::rfpdp_in_t                 in_beat_i,
  input  logic signed [rfpdp_pkg::PEN_BITS-1:0] penalty_i,
  input  logic                                 s1_ready_i,
  input  rfpdp_pkg::rfpdp_wb_t                 wb_i,
  input  logic signed [SCORE_BITS-1:0]         wb_data_i,
  output logic                                 rd_en_o,
  output logic [rfpdp_pkg::MEM_ADDR_BITS-1:0]  rd_addr_a_o,
  output logic [rfpdp_pkg::MEM_ADDR_BITS-1:0]  rd_addr_b_o,
  output logic                                 s1_valid_o,
  output rfpdp_pkg::rfpdp_issue_t              s1_o,
  output logic signed [SCORE_BITS-1:0]         byp_data_o,
  output logic signed [SCORE_BITS-1:0]         prev6_o
);
  import rfpdp_pkg::*;

  logic                         s1_valid_q;
  rfpdp_issue_t                 s1_q, s1_d;
  logic signed [SCORE_BITS-1:0] byp_data_q;
  logic                         first_q;
  logic [PHASE_BITS-1:0]        phase_q;
  logic [CODING_ROWS-1:0]       curslot_q, prevslot_q;
  logic signed [SCORE_BITS-1:0] cur6_q, prev6_q;

  logic                         accept;
  logic [FRAME_BITS-1:0]        row, row_a, row_b, phase_row;
  logic                         bad, coding, open, swap, pos, first_eff, wslot;
  logic [PHASE_BITS-1:0]        phase_eff, mod3;
  logic [CODING_ROWS-1:0]       prevslot_eff;
  logic [MEM_ADDR_BITS-1:0]     addr_a, addr_b, waddr;
  logic signed [ADD_BITS-1:0]   cell_x, pen_x;
  logic                         wb_mem, wb_row6;

  assign in_stall_o = s1_valid_q & ~s1_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign wb_mem     = wb_i.we & ~wb_i.row6;
  assign wb_row6    = wb_i.we & wb_i.row6;

  // Column opening and phase
  always_comb begin
    row    = in_beat_i.frame_index;
    bad    = (row == ROW_INVALID);
    coding = (row < ROW_NONCODING);
    open   = (row == ROW_FIRST);
    swap   = open & ~in_beat_i.sequence_start;
    if (open) begin
      first_eff = in_beat_i.sequence_start;
      if (in_beat_i.sequence_start || phase_q == PHASE_LAST) begin
        phase_eff = PHASE_FIRST;
      end else begin
        phase_eff = phase_q + 1'b1;
      end
    end else begin
      first_eff = first_q;
      phase_eff = phase_q;
    end
    prevslot_eff = swap ? curslot_q : prevslot_q;
  end

  // Predecessor rows and memory addresses
  always_comb begin
    pos        = (row < ROW_STRAND);
    mod3       = pos ? row[PHASE_BITS-1:0] : PHASE_BITS'(row - ROW_STRAND);
    phase_row  = {1'b0, phase_eff};
    row_a      = coding ? row : phase_row;
    if (coding) begin
      row_b = pos ? row + ROW_STRAND : row - ROW_STRAND;
    end else begin
      row_b = phase_row + ROW_STRAND;
    end
    addr_a = {row_a, prevslot_eff[row_a]};
    addr_b = {row_b, prevslot_eff[row_b]};
    // write goes to the slot that is not the previous-column snapshot
    if (curslot_q[row_a] == prevslot_eff[row_a]) begin
      wslot = ~prevslot_eff[row_a];
    end else begin
      wslot = curslot_q[row_a];
    end
    waddr = {row_a, wslot};
  end

  // Penalty pre-add: own row +0, noncoding +q, other strand +2q
  always_comb begin
    cell_x = ADD_BITS'(in_beat_i.cell_score);
    pen_x  = coding ? ADD_BITS'(penalty_i) : '0;
    s1_d            = '0;
    s1_d.row        = row;
    s1_d.first_col  = first_eff;
    s1_d.three_pred = ~coding | (mod3 == phase_eff);
    s1_d.bad        = bad;
    s1_d.byp_a      = wb_mem & (wb_i.waddr == addr_a);
    s1_d.byp_b      = wb_mem & (wb_i.waddr == addr_b);
    s1_d.row_a      = row_a;
    s1_d.row_b      = row_b;
    s1_d.cell_ext   = cell_x;
    s1_d.add6       = cell_x + pen_x;
    s1_d.addb       = cell_x + (pen_x <<< 1);
    s1_d.waddr      = waddr;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      first_q    <= 1'b1;
      phase_q    <= PHASE_FIRST;
      curslot_q  <= '0;
      prevslot_q <= '0;
      cur6_q     <= '0;
      prev6_q    <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_ready_i) begin
        s1_valid_q <= 1'b0;
      end
      if (wb_row6) begin
        cur6_q <= wb_data_i;
      end
      if (accept && !bad) begin
        first_q <= first_eff;
        phase_q <= phase_eff;
        if (swap) begin
          prevslot_q <= curslot_q;
          prev6_q    <= wb_row6 ? wb_data_i : cur6_q;
        end
        if (coding) begin
          curslot_q[row_a] <= wslot;
        end
      end
    end
  end

  // Beat payload and bypass data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= s1_d;
      byp_data_q <= wb_data_i;
    end
  end

  assign rd_en_o     = accept;
  assign rd_addr_a_o = addr_a;
  assign rd_addr_b_o = addr_b;
  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign byp_data_o  = byp_data_q;
  assign prev6_o     = prev6_q;

endmodule

`default_nettype wire

>>> hw/rtl/rfpdp_select.sv
// rfpdp_select: candidate sums, saturation, first-wins maximum and the output
// register; drives write-back of the winning score. Uses rfpdp_pkg.
`default_nettype none

module rfpdp_select #(
  parameter int SCORE_BITS = rfpdp_pkg::SCORE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s1_valid_i,
  input  rfpdp_pkg::rfpdp_issue_t       s1_i,
  input  logic signed [SCORE_BITS-1:0]  rd_data_a_i,
  input  logic signed [SCORE_BITS-1:0]  rd_data_b_i,
  input  logic signed [SCORE_BITS-1:0]  byp_data_i,
  input  logic signed [SCORE_BITS-1:0]  prev6_i,
  output logic                          s1_ready_o,
  output rfpdp_pkg::rfpdp_wb_t          wb_o,
  output logic signed [SCORE_BITS-1:0]  wb_data_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rfpdp_pkg::rfpdp_out_t         out_beat_o
);
  import rfpdp_pkg::*;

  localparam int SUM_W = ((SCORE_BITS > ADD_BITS) ? SCORE_BITS : ADD_BITS) + 1;
  localparam int SAT_W = (SCORE_BITS > OUT_BITS) ? SCORE_BITS : OUT_BITS;

  // Saturate an exact sum to the score range
  function automatic logic signed [SCORE_BITS-1:0] clamp_score(
    input logic signed [SUM_W-1:0] v
  );
    logic [SUM_W-SCORE_BITS:0] upper;
    upper = v[SUM_W-1:SCORE_BITS-1];
    if (&upper || ~|upper) begin
      return v[SCORE_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SCORE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SCORE_BITS-1){1'b1}}};
    end
  endfunction

  logic                         out_valid_q, fire;
  rfpdp_out_t                   out_beat_q, out_beat_d;
  logic signed [SCORE_BITS-1:0] pa, pb, cand_a, cand_6, cand_b, best;
  logic signed [ADD_BITS-1:0]   cell_v, add6, addb;
  logic [FRAME_BITS-1:0]        back;
  logic signed [SAT_W-1:0]      best_x;
  logic [SAT_W-OUT_BITS:0]      best_up;
  logic signed [OUT_BITS-1:0]   path;

  assign s1_ready_o = ~out_valid_q | ~out_stall_i;
  assign fire       = s1_valid_i & s1_ready_o;

  // Candidates from the three predecessor rows
  always_comb begin
    cell_v = s1_i.cell_ext;
    add6   = s1_i.add6;
    addb   = s1_i.addb;
    pa     = s1_i.byp_a ? byp_data_i : rd_data_a_i;
    pb     = s1_i.byp_b ? byp_data_i : rd_data_b_i;
    cand_a = clamp_score(SUM_W'(pa) + SUM_W'(cell_v));
    cand_6 = clamp_score(SUM_W'(prev6_i) + SUM_W'(add6));
    cand_b = clamp_score(SUM_W'(pb) + SUM_W'(addb));
  end

  // First candidate wins ties
  always_comb begin
    if (s1_i.first_col) begin
      best = clamp_score(SUM_W'(cell_v));
      back = s1_i.row;
    end else begin
      best = cand_a;
      back = s1_i.row_a;
      if (s1_i.three_pred) begin
        if (cand_6 > best) begin
          best = cand_6;
          back = ROW_NONCODING;
        end
        if (cand_b > best) begin
          best = cand_b;
          back = s1_i.row_b;
        end
      end
    end
  end

  // Output saturation to the port width
  always_comb begin
    best_x  = SAT_W'(best);
    best_up = best_x[SAT_W-1:OUT_BITS-1];
    if (&best_up || ~|best_up) begin
      path = best_x[OUT_BITS-1:0];
    end else if (best_x[SAT_W-1]) begin
      path = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      path = {1'b0, {(OUT_BITS-1){1'b1}}};
    end
    if (s1_i.bad) begin
      out_beat_d = '0;
    end else begin
      out_beat_d.path_score = path;
      out_beat_d.back_frame = back;
    end
  end

  // Write-back of the finished score
  always_comb begin
    wb_o.we    = fire & ~s1_i.bad;
    wb_o.row6  = (s1_i.row == ROW_NONCODING);
    wb_o.waddr = s1_i.waddr;
    wb_data_o  = best;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

>>> hw/rtl/reading_frame_path_dp_core.sv
// reading_frame_path_dp_core: top level of the seven-frame max-sum path scorer.
// Instantiates rfpdp_issue, rfpdp_score_mem and rfpdp_select; uses rfpdp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) carries one score cell
//   per beat, frames in ascending order within a column; frame 0 with
//   sequence_start set opens the first column of a new sequence.
//   Output channel (out_valid_o / out_stall_i / out_beat_o) returns one beat per
//   input beat: the best path score into that cell and its predecessor frame.
//   cfg_we_i / cfg_wdata_i write the frame change penalty; write it only while
//   no beat is in flight.
// Pipeline: an accepted beat passes the read stage, then the output register,
//   before out_valid_o rises.
// Throughput: 1 beat per cycle unless the output stalls. The previous column
//   lives in a 12-entry score memory with a registered read; each write-back is
//   forwarded to the next beat's read, so back-to-back cells never wait.
// Reset: the penalty is cleared, all stored scores read as zero, the column
//   phase is zero and cells before the first frame 0 count as a first column.
//   No clearing pass is needed.
// Stall: while out_stall_i holds a waiting beat, one more beat is taken into
//   the read stage, then in_stall_o rises until the output drains.
`default_nettype none

module reading_frame_path_dp_core #(
  parameter int SCORE_BITS = rfpdp_pkg::SCORE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic signed [rfpdp_pkg::PEN_BITS-1:0] cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  rfpdp_pkg::rfpdp_in_t                  in_beat_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output rfpdp_pkg::rfpdp_out_t                 out_beat_o
);
  import rfpdp_pkg::*;

  logic signed [PEN_BITS-1:0]   penalty_q;
  logic                         s1_valid, s1_ready, s1_fire, rd_en;
  rfpdp_issue_t                 s1;
  rfpdp_wb_t                    wb;
  logic signed [SCORE_BITS-1:0] wb_data, byp_data, prev6, rd_data_a, rd_data_b;
  logic [MEM_ADDR_BITS-1:0]     rd_addr_a, rd_addr_b;

  // Penalty register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      penalty_q <= '0;
    end else if (cfg_we_i) begin
      penalty_q <= cfg_wdata_i;
    end
  end

  rfpdp_issue #(.SCORE_BITS(SCORE_BITS)) u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .penalty_i   (penalty_q),
    .s1_ready_i  (s1_ready),
    .wb_i        (wb),
    .wb_data_i   (wb_data),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .byp_data_o  (byp_data),
    .prev6_o     (prev6)
  );

  rfpdp_score_mem #(.SCORE_BITS(SCORE_BITS)) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .wr_en_i     (wb.we & ~wb.row6),
    .wr_addr_i   (wb.waddr),
    .wr_data_i   (wb_data),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  rfpdp_select #(.SCORE_BITS(SCORE_BITS)) u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .byp_data_i  (byp_data),
    .prev6_i     (prev6),
    .s1_ready_o  (s1_ready),
    .wb_o        (wb),
    .wb_data_o   (wb_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  assign s1_fire = s1_valid & s1_ready;

  // Input backpressure only comes from a full, stalled output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output beat");

  // A beat leaving the read stage shows up on the output next cycle
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("read stage fired but no output beat followed");

  // The predecessor frame is always a real frame
  a_back_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.back_frame != ROW_INVALID))
    else $error("back_frame out of range");

  // Invalid beats never write back
  a_no_bad_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1.bad) |-> !wb.we)
    else $error("invalid frame beat wrote a score");

endmodule

`default_nettype wire

>>> tb/tb_reading_frame_path_dp_core.sv
// Self-checking testbench for reading_frame_path_dp_core: directed score cells, then
// random columns with noise under several penalty settings, checked against a predictor.
// Depends on rfpdp_pkg and reading_frame_path_dp_core only.
`timescale 1ns / 1ps

module tb_reading_frame_path_dp_core;
  import rfpdp_pkg::*;

  localparam longint SCORE_HI    = 64'sd2147483647;
  localparam longint SCORE_LO    = -SCORE_HI - 1;
  localparam int     HOLD_CYCLES = 80;
  localparam int     IDLE_LIMIT  = 4000;
  localparam int     PHASE_CELLS = 100;

  typedef struct {
    rfpdp_in_t  beat;
    bit         typed;
    rfpdp_out_t want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic signed [PEN_BITS-1:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  rfpdp_in_t  in_beat_i;
  logic       out_valid_o;
  logic       out_stall_i;
  rfpdp_out_t out_beat_o;

  // Predictor state
  longint          prev_col [FRAME_COUNT];
  longint          cur_col  [FRAME_COUNT];
  logic [PHASE_BITS-1:0] col_phase;
  bit              first_col;
  longint          penalty;

  rfpdp_out_t pending_paths [$];
  dir_row_t   dir_tab [$];

  int  err_count;
  int  cells_sent;
  int  paths_checked;
  int  seq_count;
  int  pen_writes;
  int  idle_cycles;
  bit  hold_req;
  bit  quiet_in;
  bit  quiet_out;

  reading_frame_path_dp_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Best path score into one cell; updates the column state like the block does
  function automatic rfpdp_out_t best_path_into_cell(input rfpdp_in_t c);
    int         row;
    int         cur;
    int         j;
    int         acur;
    int         npred;
    int         p;
    int         prow;
    int         back;
    int         pred [3];
    longint     cell_v;
    longint     pen;
    longint     cand;
    longint     best;
    rfpdp_out_t r;
    row    = int'(c.frame_index);
    cell_v = $signed(c.cell_score);
    best   = 0;
    back   = 0;
    if (c.frame_index == ROW_INVALID) begin
      r = '0;
      return r;
    end
    if (c.frame_index == ROW_FIRST) begin
      if (c.sequence_start) begin
        first_col = 1'b1;
        col_phase = PHASE_FIRST;
      end else begin
        for (int i = 0; i < FRAME_COUNT; i++) prev_col[i] = cur_col[i];
        first_col = 1'b0;
        col_phase = (col_phase >= PHASE_LAST) ? PHASE_FIRST : col_phase + 1'b1;
      end
    end
    if (first_col) begin
      best = cell_v;
      back = row;
    end else begin
      // signed frame: rows 0..2 -> +1..+3, 3..5 -> -1..-3, 6 -> noncoding
      cur  = (row < 3) ? row + 1 : (row < 6) ? 2 - row : 0;
      j    = int'(col_phase) + 1;
      acur = (cur < 0) ? -cur : cur;
      if (cur == 0) begin
        pred = '{j, 0, -j};
        npred = 3;
      end else if (acur == j) begin
        pred = '{cur, 0, -cur};
        npred = 3;
      end else begin
        pred = '{cur, 0, 0};
        npred = 1;
      end
      for (int k = 0; k < npred; k++) begin
        p    = pred[k];
        prow = (p > 0) ? p - 1 : (p < 0) ? 2 - p : int'(ROW_NONCODING);
        if ((cur < 0 && p > 0) || (cur > 0 && p < 0)) pen = 2 * penalty;
        else if (cur != 0 && p != cur)                pen = penalty;
        else                                          pen = 0;
        cand = prev_col[prow] + cell_v + pen;
        if (cand > SCORE_HI) cand = SCORE_HI;
        if (cand < SCORE_LO) cand = SCORE_LO;
        // first candidate keeps ties
        if (k == 0 || cand > best) begin
          best = cand;
          back = prow;
        end
      end
    end
    cur_col[row] = best;
    r.path_score = best[OUT_BITS-1:0];
    r.back_frame = back[FRAME_BITS-1:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CELL_BITS-1:0] rand_score();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fff_ffff;
    if (r == 1) return 32'h8000_0000;
    if (r < 5)  return $urandom;
    return $urandom_range(0, 4000) - 2000;
  endfunction

  task automatic add_row(input bit start, input logic [FRAME_BITS-1:0] frame,
                         input logic [CELL_BITS-1:0] score, input bit typed,
                         input logic [OUT_BITS-1:0] want_score,
                         input logic [FRAME_BITS-1:0] want_back);
    dir_row_t d;
    d.beat.sequence_start = start;
    d.beat.frame_index    = frame;
    d.beat.cell_score     = score;
    d.typed               = typed;
    d.want.path_score     = want_score;
    d.want.back_frame     = want_back;
    dir_tab.push_back(d);
  endtask

  // Offer one beat after an optional gap; record the expected path on acceptance
  task automatic offer_cell(input rfpdp_in_t c, input bit typed, input rfpdp_out_t want);
    int         g;
    rfpdp_out_t predicted;
    g = quiet_in ? 0 : gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    predicted = best_path_into_cell(c);
    pending_paths.push_back(typed ? want : predicted);
    cells_sent++;
  endtask

  task automatic offer_random(input bit start, input logic [FRAME_BITS-1:0] frame);
    rfpdp_in_t c;
    c.sequence_start = start;
    c.frame_index    = frame;
    c.cell_score     = rand_score();
    offer_cell(c, 1'b0, '0);
  endtask

  // Drain everything in flight, then write the penalty while the block is idle
  task automatic set_penalty(input logic [PEN_BITS-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_paths.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    penalty = $signed(value);
    pen_writes++;
  endtask

  // Receiver: random stall stretches, plus one long hold-off on request
  initial begin : stall_driver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = quiet_out ? 0 : gap_len();
      end
    end
  end

  // Compare each output beat with the oldest expected path
  always @(posedge clk_i) begin : path_check
    rfpdp_out_t exp_path;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_paths.size() == 0) begin
        $display("%0t: unexpected beat score %0d back %0d", $time,
                 $signed(out_beat_o.path_score), out_beat_o.back_frame);
        err_count++;
      end else begin
        exp_path = pending_paths.pop_front();
        paths_checked++;
        if (out_beat_o.path_score !== exp_path.path_score) begin
          $display("%0t: path_score expected %0d actual %0d", $time,
                   $signed(exp_path.path_score), $signed(out_beat_o.path_score));
          err_count++;
        end
        if (out_beat_o.back_frame !== exp_path.back_frame) begin
          $display("%0t: back_frame expected %0d actual %0d", $time,
                   exp_path.back_frame, out_beat_o.back_frame);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : main_seq
    logic [PEN_BITS-1:0] pen_plan [6];
    int                  sent0;
    int                  r;
    int                  drop;
    bit                  st;
    rfpdp_in_t           c;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_beat_i   = '0;
    out_stall_i = 1'b0;
    hold_req    = 1'b0;
    quiet_in    = 1'b0;
    quiet_out   = 1'b0;
    err_count   = 0;
    cells_sent  = 0;
    paths_checked = 0;
    seq_count   = 0;
    pen_writes  = 0;
    idle_cycles = 0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      prev_col[i] = 0;
      cur_col[i]  = 0;
    end
    col_phase = PHASE_FIRST;
    first_col = 1'b1;
    penalty   = 0;

    pen_plan = '{32'sd65536, -32'sd131072, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0};
    pen_plan[5] = $urandom;

    // Directed cells, penalty at its reset value of zero
    // before any frame 0 the cells count as a first column; start on other frames ignored
    add_row(1'b0, 3'd3, 32'd5, 1'b1, 32'd5, 3'd3);
    add_row(1'b1, 3'd5, -32'sd7, 1'b1, -32'sd7, 3'd5);
    // invalid frame returns zero and leaves state alone
    add_row(1'b0, ROW_INVALID, 32'd123, 1'b1, 32'd0, 3'd0);
    // first column of a sequence, extremes copied through
    add_row(1'b1, ROW_FIRST, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 3'd0);
    add_row(1'b0, 3'd1, 32'h8000_0000, 1'b1, 32'h8000_0000, 3'd1);
    add_row(1'b0, 3'd2, 32'd100, 1'b1, 32'd100, 3'd2);
    add_row(1'b0, 3'd3, -32'sd100, 1'b1, -32'sd100, 3'd3);
    add_row(1'b0, 3'd4, 32'h0000_ffff, 1'b1, 32'h0000_ffff, 3'd4);
    add_row(1'b0, 3'd5, 32'hffff_0000, 1'b1, 32'hffff_0000, 3'd5);
    add_row(1'b0, ROW_NONCODING, 32'd0, 1'b1, 32'd0, ROW_NONCODING);
    // second column: positive saturation, then mixed predecessors
    add_row(1'b0, ROW_FIRST, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 3'd0);
    add_row(1'b0, 3'd1, 32'd5, 1'b0, '0, '0);
    add_row(1'b0, 3'd2, 32'h8000_0000, 1'b0, '0, '0);
    // negative saturation; start mark on frame 3 has no effect
    add_row(1'b1, 3'd3, 32'h8000_0000, 1'b1, 32'h8000_0000, 3'd3);
    add_row(1'b0, 3'd4, 32'd0, 1'b0, '0, '0);
    // frame 5 skipped, noncoding repeated
    add_row(1'b0, ROW_NONCODING, 32'd1, 1'b0, '0, '0);
    add_row(1'b0, ROW_NONCODING, 32'd2, 1'b0, '0, '0);
    // third column with skipped frames
    add_row(1'b0, ROW_FIRST, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, 3'd2, 32'd7, 1'b0, '0, '0);
    add_row(1'b0, 3'd5, 32'd0, 1'b0, '0, '0);
    // all-zero column, then a three-way tie keeps the first predecessor
    add_row(1'b1, ROW_FIRST, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, 3'd1, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, 3'd4, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, ROW_NONCODING, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, ROW_FIRST, 32'd0, 1'b0, '0, '0);
    add_row(1'b0, 3'd1, 32'd0, 1'b1, 32'd0, 3'd1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) offer_cell(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    // Random phases, one penalty setting each (reset value first)
    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) set_penalty(pen_plan[ph-1]);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering
        quiet_in = 1'b1;
        hold_req = 1'b1;
      end
      sent0 = cells_sent;
      while (cells_sent - sent0 < PHASE_CELLS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // well-formed column, new sequence now and then
          st = (cells_sent == sent0) || ($urandom_range(0, 7) == 0);
          if (st) seq_count++;
          offer_random(st, ROW_FIRST);
          for (int f = 1; f < FRAME_COUNT; f++) begin
            offer_random(1'($urandom_range(0, 1)), FRAME_BITS'(f));
          end
        end else if (r < 90) begin
          // broken column: one frame sometimes doubled
          drop = $urandom_range(0, FRAME_COUNT - 1);
          for (int f = 0; f < FRAME_COUNT; f++) begin
            if (f != drop || $urandom_range(0, 1)) offer_random(1'b0, FRAME_BITS'(f));
            if (f == drop) offer_random(1'b0, FRAME_BITS'(f));
          end
        end else begin
          // noise: any start mark, any frame code
          repeat ($urandom_range(1, 4)) begin
            c.sequence_start = 1'($urandom_range(0, 1));
            c.frame_index    = FRAME_BITS'($urandom_range(0, 7));
            c.cell_score     = rand_score();
            offer_cell(c, 1'b0, '0);
          end
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_paths.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Sent %0d cells (%0d random sequences), checked %0d paths",
             cells_sent, seq_count, paths_checked);
    $display("Penalty written %0d times incl. both extremes; %0d mismatches",
             pen_writes, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
